// ===== rtl/b128enc_pkg.sv =====
package b128enc_pkg;

  localparam int unsigned SymbolWidth = 7;
  localparam int unsigned GroupBytes  = 7;

  typedef logic [SymbolWidth-1:0] symbol_t;
  typedef logic [2:0]             group_pos_t;

  // printable Latin-1 alphabet, indexed by 7-bit symbol
  localparam logic [7:0] ALPHABET [128] = '{
    8'h21, 8'h23, 8'h24, 8'h5E, 8'h26, 8'h27, 8'h28, 8'h29,
    8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A,
    8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43,
    8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B,
    8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h5F,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
    8'h68, 8'h6A, 8'h69, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
    8'h78, 8'h79, 8'h7A, 8'h5B, 8'h5D, 8'h7B, 8'h7C, 8'h7D,
    8'h7E, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6,
    8'hC7, 8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE,
    8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6,
    8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hE0,
    8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE9, 8'hE8
  };

  // mask of the n low bits, n in 0..7
  function automatic symbol_t low_mask(group_pos_t n);
    unique case (n)
      3'd0:    low_mask = 7'h00;
      3'd1:    low_mask = 7'h01;
      3'd2:    low_mask = 7'h03;
      3'd3:    low_mask = 7'h07;
      3'd4:    low_mask = 7'h0F;
      3'd5:    low_mask = 7'h1F;
      3'd6:    low_mask = 7'h3F;
      default: low_mask = 7'h7F;
    endcase
  endfunction

endpackage

// ===== rtl/base128_text_encoder.sv =====
// Channel  | Handshake             | Payload                 | Direction
// ---------+-----------------------+-------------------------+----------
// in       | in_valid / in_stall   | data_byte, final_byte   | into block
// out      | out_valid / out_stall | code_char, final_char   | out of block
//
// One byte is taken per cycle while in_stall is low. A byte that closes a
// seven-byte group, or that ends a message, gives two characters and holds
// the byte stage while the second character drains through the result
// register. An accepted byte passes the byte stage, then the result register.
// Reset (rst, synchronous) empties both stages and clears the bit carry
// and group position. out_stall holds the result register; the byte stage
// keeps taking items until it too is full.
module base128_text_encoder
  import b128enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] code_char,
  output logic       final_char
);

  // byte stage
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_final;

  // second character waiting behind the result register
  logic       p_valid;
  logic [7:0] p_char;
  logic       p_final;

  // encoder state
  symbol_t    bit_carry;
  group_pos_t group_position;
  symbol_t    bit_carry_next;
  group_pos_t group_position_next;

  logic       out_free;
  logic       a_move;
  logic       in_take;

  group_pos_t pos;
  group_pos_t pos_next;
  logic [14:0] joined;
  symbol_t    first_sym;
  symbol_t    held;
  symbol_t    second_sym;
  logic       two_chars;

  // result register can load when empty or being taken
  assign out_free = !out_valid || !out_stall;
  // byte stage retires only when the pending slot is empty
  assign a_move   = a_valid && !p_valid && out_free;
  assign in_stall = a_valid && !a_move;
  assign in_take  = in_valid && !in_stall;

  // split the byte: carried bits above its top bits form the first symbol,
  // its low bits become the new carry
  always_comb begin
    pos = (group_position > 3'd6) ? 3'd0 : group_position;
    pos_next = pos + 3'd1;
    joined = {bit_carry & low_mask(pos), a_byte};
    first_sym = symbol_t'(joined >> (pos + 4'd1));
    held = symbol_t'(a_byte) & low_mask(pos_next);
    // pad missing low bits with zeros; a closed group needs no shift
    second_sym = symbol_t'(held << (3'd7 - pos_next));
    two_chars = (pos_next == group_pos_t'(GroupBytes)) || a_final;
    if (two_chars) begin
      bit_carry_next      = '0;
      group_position_next = '0;
    end else begin
      bit_carry_next      = held;
      group_position_next = pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
    if (in_take) begin
      a_byte  <= data_byte;
      a_final <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_carry      <= '0;
      group_position <= '0;
    end else if (a_move) begin
      bit_carry      <= bit_carry_next;
      group_position <= group_position_next;
    end
  end

  // result register and pending slot: drain the slot first, then load
  // fresh characters from the byte stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      p_valid   <= 1'b0;
    end else if (out_free) begin
      if (p_valid) begin
        out_valid <= 1'b1;
        p_valid   <= 1'b0;
      end else if (a_move) begin
        out_valid <= 1'b1;
        p_valid   <= two_chars;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (p_valid) begin
        code_char  <= p_char;
        final_char <= p_final;
      end else if (a_move) begin
        code_char  <= ALPHABET[first_sym];
        final_char <= 1'b0;
        p_char     <= ALPHABET[second_sym];
        p_final    <= a_final;
      end
    end
  end

  // a pending character always sits behind a full result register
  assert property (@(posedge clk) disable iff (rst) p_valid |-> out_valid)
    else $error("pending character without result register");

  // group position stays within a seven-byte group
  assert property (@(posedge clk) disable iff (rst) group_position <= 3'd6)
    else $error("group position out of range");

  // a closed message leaves the state at its reset value
  assert property (@(posedge clk) disable iff (rst)
    (a_move && a_final) |=> (bit_carry == '0 && group_position == '0))
    else $error("state not cleared after final byte");

  // byte stage never retires while a second character still waits
  assert property (@(posedge clk) disable iff (rst) p_valid |-> !a_move)
    else $error("byte stage retired over pending character");

endmodule
